// ===== rtl/iee_pkg.sv =====
package iee_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_SUB    = 3'd1;
  localparam logic [2:0] OP_MUL    = 3'd2;
  localparam logic [2:0] OP_DIV    = 3'd3;
  localparam logic [2:0] OP_LPAREN = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIVZERO   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_NINE   = 8'd57;

  // commands from controller to datapath
  typedef struct packed {
    logic       digit;      // accumulate digit
    logic       flush;      // push accumulator if in number
    logic       push_op;    // push op_code onto operator stack
    logic [2:0] op_code;
    logic       pop_op;     // drop top operator
    logic       red_start;  // pop top operator and operands, start arithmetic
    logic       clear;      // return to reset state
    logic [1:0] set_err;    // latch error if nonzero and none yet
  } cmd_t;

  typedef struct packed {
    logic [1:0] err;
    logic       opr_empty;
    logic [2:0] opr_top;
    logic       opd_one;
    logic       red_busy;   // reduction in flight
  } sts_t;

  function automatic logic [1:0] prec_of(input logic [2:0] op);
    if (op == OP_MUL || op == OP_DIV) return 2'd2;
    if (op == OP_ADD || op == OP_SUB) return 2'd1;
    return 2'd0;
  endfunction

endpackage

// ===== rtl/iee_divider.sv =====
module iee_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        neg;
  logic [32:0] trial;

  assign trial = {rem_q, quo_q[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        neg <= dividend[31] ^ divisor[31];
        rem_q <= '0;
        quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
        dvs <= divisor[31] ? (32'd0 - divisor) : divisor;
      end else if (busy) begin
        // one restoring step per cycle
        if (!trial[32]) begin
          rem_q <= trial[31:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= {rem_q[30:0], quo_q[31]};
          quo_q <= {quo_q[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? (32'd0 - quo_q) : quo_q;

endmodule

// ===== rtl/iee_datapath.sv =====
module iee_datapath #(
  parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  iee_pkg::cmd_t cmd,
  input  logic [7:0]    char_code,
  output iee_pkg::sts_t sts,
  output logic [31:0]   result
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [31:0] opd_mem [STACK_DEPTH];
  logic [2:0]  opr_mem [STACK_DEPTH];
  logic [CW-1:0] opd_cnt, opr_cnt;
  logic [31:0] acc;
  logic        in_num;
  logic [1:0]  err;
  logic [2:0]  opr_top;
  logic [31:0] rd_data;
  logic [31:0] a_reg, b_reg;
  logic [2:0]  op_reg;
  logic [2:0]  phase;
  logic [31:0] prod;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_RDB  = 3'd1;
  localparam logic [2:0] PH_RDA  = 3'd2;
  localparam logic [2:0] PH_EXEC = 3'd3;
  localparam logic [2:0] PH_DIV  = 3'd4;
  localparam logic [2:0] PH_PUSH = 3'd5;

  logic        div_start, div_busy, div_done;
  logic [31:0] div_q;
  logic [31:0] res_reg;
  logic        full_opd, full_opr;
  logic [AW-1:0] rd_addr;
  logic        rd_en;

  iee_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(a_reg), .divisor(b_reg),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  assign full_opd = (opd_cnt == CW'(STACK_DEPTH));
  assign full_opr = (opr_cnt == CW'(STACK_DEPTH));
  assign div_start = (phase == PH_EXEC) && (op_reg == iee_pkg::OP_DIV) && (b_reg != 32'd0);

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= opd_mem[rd_addr];
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    if (cmd.red_start && opd_cnt >= CW'(2)) begin
      rd_en = 1'b1;
      rd_addr = AW'(opd_cnt - CW'(1));
    end else if (phase == PH_RDB) begin
      rd_en = 1'b1;
      rd_addr = AW'(opd_cnt);
    end else if (opd_cnt != '0) begin
      rd_en = 1'b1;
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opd_cnt <= '0;
      opr_cnt <= '0;
      acc <= '0;
      in_num <= 1'b0;
      err <= iee_pkg::ST_OK;
      phase <= PH_IDLE;
    end else if (cmd.clear) begin
      opd_cnt <= '0;
      opr_cnt <= '0;
      acc <= '0;
      in_num <= 1'b0;
      err <= iee_pkg::ST_OK;
      phase <= PH_IDLE;
    end else begin
      if (cmd.set_err != iee_pkg::ST_OK && err == iee_pkg::ST_OK) err <= cmd.set_err;
      if (cmd.digit) begin
        acc <= (acc << 3) + (acc << 1) + {24'd0, char_code - iee_pkg::CH_ZERO};
        in_num <= 1'b1;
      end
      if (cmd.flush && in_num) begin
        if (full_opd) begin
          if (err == iee_pkg::ST_OK) err <= iee_pkg::ST_OVERFLOW;
        end else begin
          opd_mem[AW'(opd_cnt)] <= acc;
          opd_cnt <= opd_cnt + CW'(1);
        end
        acc <= '0;
        in_num <= 1'b0;
      end
      if (cmd.push_op) begin
        if (full_opr) begin
          if (err == iee_pkg::ST_OK) err <= iee_pkg::ST_OVERFLOW;
        end else begin
          opr_mem[AW'(opr_cnt)] <= cmd.op_code;
          opr_cnt <= opr_cnt + CW'(1);
        end
      end
      if (cmd.pop_op) opr_cnt <= opr_cnt - CW'(1);
      if (cmd.red_start) begin
        op_reg <= opr_top;
        opr_cnt <= opr_cnt - CW'(1);
        if (opd_cnt < CW'(2)) begin
          if (err == iee_pkg::ST_OK) err <= iee_pkg::ST_MALFORMED;
        end else begin
          opd_cnt <= opd_cnt - CW'(2);
          phase <= PH_RDB;
        end
      end
      case (phase)
        PH_RDB: begin
          b_reg <= rd_data;
          phase <= PH_RDA;
        end
        PH_RDA: begin
          a_reg <= rd_data;
          phase <= PH_EXEC;
        end
        PH_EXEC: begin
          case (op_reg)
            iee_pkg::OP_ADD: begin res_reg <= a_reg + b_reg; phase <= PH_PUSH; end
            iee_pkg::OP_SUB: begin res_reg <= a_reg - b_reg; phase <= PH_PUSH; end
            iee_pkg::OP_MUL: begin res_reg <= prod; phase <= PH_PUSH; end
            iee_pkg::OP_DIV: begin
              if (b_reg == 32'd0) begin
                if (err == iee_pkg::ST_OK) err <= iee_pkg::ST_DIVZERO;
                phase <= PH_IDLE;
              end else begin
                phase <= PH_DIV;
              end
            end
            default: begin
              if (err == iee_pkg::ST_OK) err <= iee_pkg::ST_MALFORMED;
              phase <= PH_IDLE;
            end
          endcase
        end
        PH_DIV: begin
          if (div_done) begin
            res_reg <= div_q;
            phase <= PH_PUSH;
          end
        end
        PH_PUSH: begin
          // two operands were popped, so there is always room
          opd_mem[AW'(opd_cnt)] <= res_reg;
          opd_cnt <= opd_cnt + CW'(1);
          phase <= PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  assign prod = a_reg * b_reg;
  assign opr_top = opr_mem[AW'(opr_cnt - CW'(1))];
  assign result = rd_data;

  always_comb begin
    sts.err = err;
    sts.opr_empty = (opr_cnt == '0);
    sts.opr_top = opr_top;
    sts.opd_one = (opd_cnt == CW'(1));
    sts.red_busy = (phase != PH_IDLE) || div_busy;
  end

endmodule

// ===== rtl/iee_controller.sv =====
module iee_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    char_code,
  input  logic          is_end,
  input  iee_pkg::sts_t sts,
  output iee_pkg::cmd_t cmd,
  input  logic [31:0]   result,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [31:0]   value,
  output logic [1:0]    status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FLUSH = 3'd1;
  localparam logic [2:0] S_OPER  = 3'd2;
  localparam logic [2:0] S_RPAR  = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] cur_op, cur_op_next;
  logic [2:0] ret, ret_next;
  logic       take;
  logic       is_digit;
  logic [2:0] ch_op;
  logic       ch_known, ch_rpar;
  logic       fin_go;

  assign in_stall = (state != S_IDLE);
  assign take = in_valid && !in_stall;
  assign is_digit = (char_code >= iee_pkg::CH_ZERO) && (char_code <= iee_pkg::CH_NINE);
  // output register free or being emptied this cycle
  assign fin_go = !out_valid || !out_stall;

  always_comb begin
    ch_known = 1'b1;
    ch_rpar = 1'b0;
    ch_op = iee_pkg::OP_ADD;
    case (char_code)
      iee_pkg::CH_PLUS:   ch_op = iee_pkg::OP_ADD;
      iee_pkg::CH_MINUS:  ch_op = iee_pkg::OP_SUB;
      iee_pkg::CH_STAR:   ch_op = iee_pkg::OP_MUL;
      iee_pkg::CH_SLASH:  ch_op = iee_pkg::OP_DIV;
      iee_pkg::CH_LPAREN: ch_op = iee_pkg::OP_LPAREN;
      iee_pkg::CH_RPAREN: ch_rpar = 1'b1;
      default: ch_known = 1'b0;
    endcase
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    cur_op_next = cur_op;
    ret_next = ret;
    case (state)
      S_IDLE: begin
        if (take) begin
          if (is_end) begin
            if (sts.err == iee_pkg::ST_OK) cmd.flush = 1'b1;
            state_next = S_END;
          end else if (sts.err != iee_pkg::ST_OK) begin
            state_next = S_IDLE;
          end else if (is_digit) begin
            cmd.digit = 1'b1;
          end else if (!ch_known) begin
            cmd.set_err = iee_pkg::ST_MALFORMED;
          end else begin
            cmd.flush = 1'b1;
            cur_op_next = ch_op;
            state_next = ch_rpar ? S_RPAR : S_OPER;
          end
        end
      end
      S_OPER: begin
        if (sts.err != iee_pkg::ST_OK) begin
          state_next = S_IDLE;
        end else if (cur_op == iee_pkg::OP_LPAREN) begin
          cmd.push_op = 1'b1;
          cmd.op_code = cur_op;
          state_next = S_IDLE;
        end else if (!sts.opr_empty && sts.opr_top != iee_pkg::OP_LPAREN &&
                     iee_pkg::prec_of(sts.opr_top) >= iee_pkg::prec_of(cur_op)) begin
          cmd.red_start = 1'b1;
          ret_next = S_OPER;
          state_next = S_WAIT;
        end else begin
          cmd.push_op = 1'b1;
          cmd.op_code = cur_op;
          state_next = S_IDLE;
        end
      end
      S_RPAR: begin
        if (sts.err != iee_pkg::ST_OK) begin
          state_next = S_IDLE;
        end else if (sts.opr_empty) begin
          cmd.set_err = iee_pkg::ST_MALFORMED;
          state_next = S_IDLE;
        end else if (sts.opr_top == iee_pkg::OP_LPAREN) begin
          cmd.pop_op = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.red_start = 1'b1;
          ret_next = S_RPAR;
          state_next = S_WAIT;
        end
      end
      S_END: begin
        if (sts.err != iee_pkg::ST_OK) begin
          state_next = S_FIN;
        end else if (sts.opr_empty) begin
          if (!sts.opd_one) cmd.set_err = iee_pkg::ST_MALFORMED;
          state_next = S_FIN;
        end else if (sts.opr_top == iee_pkg::OP_LPAREN) begin
          cmd.set_err = iee_pkg::ST_MALFORMED;
          state_next = S_FIN;
        end else begin
          cmd.red_start = 1'b1;
          ret_next = S_END;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        // wait until the reduction phase register is back to idle and the divider is free
        if (!sts.red_busy) state_next = ret;
      end
      S_FIN: begin
        // bottom operand read registered by now
        if (fin_go) begin
          cmd.clear = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cur_op <= cur_op_next;
      ret <= ret_next;
      if (state == S_FIN && fin_go) begin
        out_valid <= 1'b1;
        status <= sts.err;
        value <= (sts.err == iee_pkg::ST_OK) ? result : 32'd0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/infix_expression_evaluator_core.sv =====
// Evaluates an integer infix expression fed one ASCII character per
// transaction; an is_end transaction closes the expression and yields one
// result transaction with value and status, after which the block is ready
// for a new expression. A digit never stalls input; each reduction that an
// operator or parenthesis triggers reads both operands in turn from the
// single-port operand stack, and / also waits on the one-bit-per-cycle
// divider. Characters of the next expression are taken while a result
// waits; after its end marker, input stalls until the previous result is taken.
module infix_expression_evaluator_core #(
  parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_code,
  input  logic               is_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic [1:0]         status
);

  iee_pkg::cmd_t cmd;
  iee_pkg::sts_t sts;
  logic [31:0]   result;
  logic [31:0]   value_u;

  iee_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .char_code(char_code), .is_end(is_end), .sts(sts), .cmd(cmd),
    .result(result), .out_valid(out_valid), .out_stall(out_stall),
    .value(value_u), .status(status)
  );

  iee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .char_code(char_code), .sts(sts),
    .result(result)
  );

  assign value = signed'(value_u);

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  localparam int DEPTH = iee_pkg::STACK_DEPTH_DEF;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         char_code;
  logic               is_end;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] value;
  logic [1:0]         status;

  infix_expression_evaluator_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .char_code(char_code), .is_end(is_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .status(status)
  );

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } char_item_t;

  typedef struct {
    logic [31:0] val;
    logic [1:0]  st;
  } eval_result_t;

  char_item_t   pending_chars[$];
  eval_result_t expected_results[$];
  int           fail_count;
  int           result_count;
  int           status_seen[4];
  bit           feed_done;
  bit           hold_long;
  bit           in_taken;

  // predictor state
  logic [31:0] opd_stk[DEPTH];
  int          opd_cnt;
  logic [2:0]  opr_stk[DEPTH];
  int          opr_cnt;
  logic [31:0] num_acc;
  bit          num_open;
  logic [1:0]  err_latch;

  function automatic int prio(logic [2:0] op);
    if (op == iee_pkg::OP_MUL || op == iee_pkg::OP_DIV) return 2;
    if (op == iee_pkg::OP_ADD || op == iee_pkg::OP_SUB) return 1;
    return 0;
  endfunction

  task automatic eval_clear();
    opd_cnt = 0;
    opr_cnt = 0;
    num_acc = 0;
    num_open = 0;
    err_latch = iee_pkg::ST_OK;
  endtask

  task automatic flag_err(logic [1:0] code);
    if (err_latch == iee_pkg::ST_OK) err_latch = code;
  endtask

  task automatic push_val(logic [31:0] v);
    if (opd_cnt >= DEPTH) flag_err(iee_pkg::ST_OVERFLOW);
    else begin
      opd_stk[opd_cnt] = v;
      opd_cnt++;
    end
  endtask

  task automatic push_opr(logic [2:0] op);
    if (opr_cnt >= DEPTH) flag_err(iee_pkg::ST_OVERFLOW);
    else begin
      opr_stk[opr_cnt] = op;
      opr_cnt++;
    end
  endtask

  task automatic apply_top();
    logic [2:0]  op;
    logic [31:0] a, b, r, ma, mb, q;
    if (opr_cnt == 0) return;
    op = opr_stk[opr_cnt-1];
    opr_cnt--;
    if (opd_cnt < 2) begin
      flag_err(iee_pkg::ST_MALFORMED);
      return;
    end
    b = opd_stk[opd_cnt-1];
    a = opd_stk[opd_cnt-2];
    opd_cnt -= 2;
    case (op)
      iee_pkg::OP_ADD: r = a + b;
      iee_pkg::OP_SUB: r = a - b;
      iee_pkg::OP_MUL: r = a * b;
      iee_pkg::OP_DIV: begin
        if (b == 0) begin
          flag_err(iee_pkg::ST_DIVZERO);
          return;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        r = (a[31] != b[31]) ? -q : q;
      end
      default: begin
        flag_err(iee_pkg::ST_MALFORMED);
        return;
      end
    endcase
    push_val(r);
  endtask

  task automatic close_number();
    if (num_open) begin
      push_val(num_acc);
      num_acc = 0;
      num_open = 0;
    end
  endtask

  task automatic eval_char(logic [7:0] c);
    logic [2:0] op;
    bit         rpar;
    rpar = 0;
    op = iee_pkg::OP_ADD;
    if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE) begin
      num_acc = num_acc * 10 + 32'(c - iee_pkg::CH_ZERO);
      num_open = 1;
      return;
    end
    case (c)
      iee_pkg::CH_PLUS:   op = iee_pkg::OP_ADD;
      iee_pkg::CH_MINUS:  op = iee_pkg::OP_SUB;
      iee_pkg::CH_STAR:   op = iee_pkg::OP_MUL;
      iee_pkg::CH_SLASH:  op = iee_pkg::OP_DIV;
      iee_pkg::CH_LPAREN: op = iee_pkg::OP_LPAREN;
      iee_pkg::CH_RPAREN: rpar = 1;
      default: begin
        flag_err(iee_pkg::ST_MALFORMED);
        return;
      end
    endcase
    close_number();
    if (err_latch != iee_pkg::ST_OK) return;
    if (rpar) begin
      while (err_latch == iee_pkg::ST_OK && opr_cnt > 0 &&
             opr_stk[opr_cnt-1] != iee_pkg::OP_LPAREN)
        apply_top();
      if (err_latch != iee_pkg::ST_OK) return;
      if (opr_cnt == 0) flag_err(iee_pkg::ST_MALFORMED);
      else opr_cnt--;
    end else if (op == iee_pkg::OP_LPAREN) begin
      push_opr(iee_pkg::OP_LPAREN);
    end else begin
      while (err_latch == iee_pkg::ST_OK && opr_cnt > 0 &&
             opr_stk[opr_cnt-1] != iee_pkg::OP_LPAREN &&
             prio(opr_stk[opr_cnt-1]) >= prio(op))
        apply_top();
      if (err_latch == iee_pkg::ST_OK) push_opr(op);
    end
  endtask

  task automatic eval_item(char_item_t it);
    eval_result_t res;
    if (!it.fin) begin
      if (err_latch == iee_pkg::ST_OK) eval_char(it.ch);
      return;
    end
    res.val = 0;
    if (err_latch == iee_pkg::ST_OK) begin
      close_number();
      while (err_latch == iee_pkg::ST_OK && opr_cnt > 0) begin
        if (opr_stk[opr_cnt-1] == iee_pkg::OP_LPAREN) begin
          flag_err(iee_pkg::ST_MALFORMED);
          break;
        end
        apply_top();
      end
      if (err_latch == iee_pkg::ST_OK && opd_cnt != 1) flag_err(iee_pkg::ST_MALFORMED);
      if (err_latch == iee_pkg::ST_OK) res.val = opd_stk[0];
    end
    res.st = err_latch;
    if (res.st != iee_pkg::ST_OK) res.val = 0;
    expected_results.push_back(res);
    eval_clear();
  endtask

  // stimulus helpers
  task automatic put_char(logic [7:0] c);
    char_item_t it;
    it.ch = c;
    it.fin = 0;
    pending_chars.push_back(it);
  endtask

  task automatic put_end();
    char_item_t it;
    it.ch = 8'($urandom);
    it.fin = 1;
    pending_chars.push_back(it);
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
    put_end();
  endtask

  task automatic put_number();
    int nd;
    nd = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
    for (int i = 0; i < nd; i++)
      put_char(iee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_oper();
    case ($urandom_range(0, 3))
      0: put_char(iee_pkg::CH_PLUS);
      1: put_char(iee_pkg::CH_MINUS);
      2: put_char(iee_pkg::CH_STAR);
      default: put_char(iee_pkg::CH_SLASH);
    endcase
  endtask

  // well-formed expression with random content
  task automatic put_term(int lvl);
    if (lvl < 3 && $urandom_range(0, 3) == 0) begin
      put_char(iee_pkg::CH_LPAREN);
      put_expr(lvl + 1);
      put_char(iee_pkg::CH_RPAREN);
    end else put_number();
  endtask

  task automatic put_expr(int lvl);
    int n;
    n = $urandom_range(0, 4);
    put_term(lvl);
    for (int i = 0; i < n; i++) begin
      put_oper();
      put_term(lvl);
    end
  endtask

  task automatic put_noise();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: put_char(8'($urandom));
        1: put_char(iee_pkg::CH_LPAREN);
        2: put_char(iee_pkg::CH_RPAREN);
        3: put_oper();
        default: put_number();
      endcase
    end
    put_end();
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: bursts with gaps
  int burst_left, gap_left;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
      burst_left = $urandom_range(1, 20);
      gap_left = 0;
    end else if (!in_valid || in_taken) begin
      if (in_valid) pending_chars.pop_front();
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 0;
      end else if (pending_chars.size() > 0) begin
        in_valid <= 1;
        char_code <= pending_chars[0].ch;
        is_end <= pending_chars[0].fin;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 0;
        feed_done = 1;
      end
    end
  end

  // prediction on acceptance
  always @(posedge clk) begin
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) eval_item('{ch: char_code, fin: is_end});
  end

  // receiver stall pattern, plus one long hold-off
  int stall_phase, hold_cycles;
  always @(negedge clk) begin
    stall_phase++;
    if (hold_long) begin
      out_stall <= 1;
      hold_cycles++;
      if (hold_cycles >= 3000) hold_long = 0;
    end else if ((stall_phase / 64) % 2 == 0) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // result monitor
  always @(posedge clk) begin
    eval_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      status_seen[status]++;
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result value=%0d status=%0d", $time, value, status);
      end else begin
        exp_r = expected_results.pop_front();
        if (value !== exp_r.val) begin
          fail_count++;
          $display("%0t: value expected %0d actual %0d", $time, $signed(exp_r.val), value);
        end
        if (status !== exp_r.st) begin
          fail_count++;
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    string deep;
    rst = 1;
    in_valid = 0;
    out_stall = 0;
    char_code = 0;
    is_end = 0;
    fail_count = 0;
    result_count = 0;
    feed_done = 0;
    hold_long = 0;
    in_taken = 0;
    hold_cycles = 0;
    stall_phase = 0;
    eval_clear();
    // directed
    put_str("1+2*3");
    put_str("(1+2)*3");
    put_str("100-7-3");
    put_str("84/4/3");
    put_str("7/0");
    put_str("2147483648/4294967295");
    put_str("0-7/2");
    put_str("99999999999");
    put_str("-5");
    put_str("2++3");
    put_str("3)");
    put_str("(3");
    put_str("2(3)");
    put_str("");
    put_str("4 2");
    put_str("255");
    put_char(8'hff); put_char(8'h00); put_end();
    deep = "";
    for (int i = 0; i < 17; i++) deep = {deep, "("};
    put_str(deep);
    deep = "";
    for (int i = 0; i < 17; i++) deep = {deep, "1+"};
    put_str({deep, "1"});
    deep = "";
    for (int i = 0; i < 16; i++) deep = {deep, "1*("};
    put_str({deep, "1"});
    put_str("1*2-3/4+5");
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // random
    while (pending_chars.size() < 800) begin
      if ($urandom_range(0, 4) != 0) begin
        put_expr(0);
        put_end();
      end else put_noise();
    end
    wait (pending_chars.size() < 600);
    @(negedge clk);
    hold_long = 1;
    while (pending_chars.size() > 0 || !feed_done) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("ran %0d expressions: ok %0d divzero %0d overflow %0d malformed %0d",
             result_count, status_seen[0], status_seen[1], status_seen[2],
             status_seen[3]);
    if (fail_count == 0 && expected_results.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/iee_pkg.sv
rtl/iee_divider.sv
rtl/iee_datapath.sv
rtl/iee_controller.sv
rtl/infix_expression_evaluator_core.sv
tb/tb_top.sv
